// ===== rtl/core/tps_pkg.sv =====
// Package for the task priority scheduler: table geometry, command and
// status codes, entry layout and the control/status bundles between units.
// No dependencies.
`default_nettype none
package tps_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W     = 3;
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 4;
  localparam int REM_W    = 7;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_RUN_SERVED = 3'd1;
  localparam logic [OP_W-1:0] OP_RUN_ID     = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_PRIO   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic [PRIO_W-1:0] PRIO_MIN  = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX  = 4'd8;
  localparam logic [REM_W-1:0]  COUNT_MIN = 7'd1;
  localparam logic [REM_W-1:0]  COUNT_MAX = 7'd99;

  localparam logic [ID_W-1:0] FIRST_ID = 16'd1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [REM_W-1:0]  rem;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             start;
    logic             scan_en;
    logic [IDX_W-1:0] scan_addr;
    logic             commit;
  } tps_cmd_t;

  typedef struct packed {
    logic out_busy;
  } tps_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/task_priority_scheduler.sv =====
// Task priority scheduler top level: controller plus datapath.
// Uses tps_pkg, tps_ctrl, tps_dp.
//
// Usage:
//   Requests enter on in_* (valid/stall). in_stall is low only while the
//   block is idle; a request is taken when in_valid is high and in_stall low.
//   Every request sweeps the task table one slot per cycle, then passes a
//   tail step and a commit step; its result shows on out_* in the cycle
//   after the commit, and a next request can be taken from that cycle
//   on. A request is not taken before the previous one has committed.
//   One result per request on out_*.
//   Results sit in an output register: a new request is taken while the
//   previous result still waits; if out_stall holds that result, the next
//   one waits in the commit step and no further request is taken.
//   cfg_* writes the policy bit (0 priority, 1 remaining count); cfg_ready
//   is always high, writes belong between requests.
//   Synchronous reset (rst_n low) empties the table, sets the id counter to
//   one and the policy to priority; no clearing pass is needed.
`default_nettype none
module task_priority_scheduler (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [tps_pkg::OP_W-1:0]        in_op,
  input  wire logic [tps_pkg::ID_W-1:0]        in_task_id,
  input  wire logic [tps_pkg::PRIO_W-1:0]      in_priority_req,
  input  wire logic [tps_pkg::REM_W-1:0]       in_exec_count,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [tps_pkg::STATUS_W-1:0]    out_status,
  output logic      [tps_pkg::ID_W-1:0]        out_result_id,
  output logic      [tps_pkg::REM_W-1:0]       out_remaining,
  output logic                                 out_retired,
  output logic      [tps_pkg::OCC_W-1:0]       out_occupancy
);
  import tps_pkg::*;

  tps_cmd_t cmd;
  tps_sts_t sts;

  assign cfg_ready = 1'b1;

  tps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .in_op           (in_op),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .in_exec_count   (in_exec_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_result_id   (out_result_id),
    .out_remaining   (out_remaining),
    .out_retired     (out_retired),
    .out_occupancy   (out_occupancy)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tps_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/tps_ctrl.sv =====
// Scheduler controller: accepts a request, sweeps the table one slot per
// cycle, then commits the result. Uses tps_pkg.
`default_nettype none
module tps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tps_pkg::tps_sts_t sts,
  output tps_pkg::tps_cmd_t      cmd
);
  import tps_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_TAIL   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    in_stall      = 1'b1;
    cmd.start     = 1'b0;
    cmd.scan_en   = 1'b0;
    cmd.scan_addr = scan_r;
    cmd.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        scan_nxt    = scan_r + IDX_W'(1);
        if (scan_r == LAST_IDX) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tps_dp.sv =====
// Scheduler datapath: request registers, task table, sweep comparator,
// commit logic and result register. Uses tps_pkg and tps_ram.
`default_nettype none
module tps_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tps_pkg::tps_cmd_t               cmd,
  output tps_pkg::tps_sts_t                    sts,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_data,
  input  wire logic [tps_pkg::OP_W-1:0]        in_op,
  input  wire logic [tps_pkg::ID_W-1:0]        in_task_id,
  input  wire logic [tps_pkg::PRIO_W-1:0]      in_priority_req,
  input  wire logic [tps_pkg::REM_W-1:0]       in_exec_count,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [tps_pkg::STATUS_W-1:0]    out_status,
  output logic      [tps_pkg::ID_W-1:0]        out_result_id,
  output logic      [tps_pkg::REM_W-1:0]       out_remaining,
  output logic                                 out_retired,
  output logic      [tps_pkg::OCC_W-1:0]       out_occupancy
);
  import tps_pkg::*;

  // request
  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   tid_r;
  logic [PRIO_W-1:0] prio_r;
  logic [REM_W-1:0]  cnt_r;
  logic [PRIO_W-1:0] prio_clamped;
  logic [REM_W-1:0]  cnt_clamped;

  // table state
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [OCC_W-1:0]       occ_r;
  logic [ID_W-1:0]        next_id_r;
  logic                   policy_r;

  // sweep
  logic             cmp_en_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             found_r;
  logic [IDX_W-1:0] best_idx_r;
  entry_t           best_r;
  entry_t           cand;
  logic             cand_valid;
  logic             better;
  logic             take;

  // ram
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  entry_t           ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // commit
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;
  logic [REM_W-1:0]    res_rem;
  logic                res_ret;
  logic                wr_en;
  entry_t              wr_data;
  logic                set_v;
  logic                clr_v;
  logic [OCC_W-1:0]    occ_nxt;

  // result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [REM_W-1:0]    out_rem_r;
  logic                out_ret_r;
  logic [OCC_W-1:0]    out_occ_r;

  always_comb begin
    priority if (in_priority_req < PRIO_MIN) prio_clamped = PRIO_MIN;
    else if (in_priority_req > PRIO_MAX)     prio_clamped = PRIO_MAX;
    else                                     prio_clamped = in_priority_req;
    priority if (in_exec_count < COUNT_MIN) cnt_clamped = COUNT_MIN;
    else if (in_exec_count > COUNT_MAX)     cnt_clamped = COUNT_MAX;
    else                                    cnt_clamped = in_exec_count;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= in_op;
      tid_r  <= in_task_id;
      prio_r <= prio_clamped;
      cnt_r  <= cnt_clamped;
    end
  end

  assign ram_we    = cmd.commit && wr_en;
  assign ram_addr  = cmd.commit ? best_idx_r : cmd.scan_addr;
  assign ram_wdata = wr_data;

  tps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.scan_en),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign cand       = entry_t'(ram_rdata);
  assign cand_valid = valid_r[cmp_idx_r];

  always_comb begin
    if (!policy_r) begin
      better = (cand.prio < best_r.prio) ||
               ((cand.prio == best_r.prio) && (cand.id < best_r.id));
    end else begin
      better = (cand.rem > best_r.rem) ||
               ((cand.rem == best_r.rem) && (cand.id < best_r.id));
    end
    priority if (op_r == OP_INSERT) begin
      take = !cand_valid && !found_r;
    end else if (op_r == OP_RUN_SERVED) begin
      take = cand_valid && (!found_r || better);
    end else begin
      take = cand_valid && (cand.id == tid_r) && !found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan_en;
      if (cmd.start) begin
        found_r <= 1'b0;
      end else if (cmp_en_r && take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmd.scan_addr;
    if (cmp_en_r && take) begin
      best_idx_r <= cmp_idx_r;
      best_r     <= cand;
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_id     = '0;
    res_rem    = '0;
    res_ret    = 1'b0;
    wr_en      = 1'b0;
    wr_data    = best_r;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    priority if (op_r == OP_INSERT) begin
      if (occ_r == OCC_W'(TABLE_DEPTH)) begin
        res_status = ST_FULL;
      end else begin
        wr_en   = 1'b1;
        wr_data = '{id: next_id_r, prio: prio_r, rem: cnt_r};
        set_v   = 1'b1;
        res_id  = next_id_r;
        res_rem = cnt_r;
      end
    end else if (op_r <= OP_SET_PRIO) begin
      priority if (occ_r == '0) begin
        res_status = ST_EMPTY;
      end else if (!found_r) begin
        res_status = ST_NOT_FOUND;
      end else begin
        res_id = best_r.id;
        priority if (op_r == OP_RUN_SERVED || op_r == OP_RUN_ID) begin
          if (best_r.rem > COUNT_MIN) begin
            wr_en       = 1'b1;
            wr_data.rem = best_r.rem - REM_W'(1);
            res_rem     = best_r.rem - REM_W'(1);
          end else begin
            clr_v   = 1'b1;
            res_ret = 1'b1;
          end
        end else if (op_r == OP_REMOVE) begin
          clr_v   = 1'b1;
          res_ret = 1'b1;
        end else begin
          wr_en        = 1'b1;
          wr_data.prio = prio_r;
          res_rem      = best_r.rem;
        end
      end
    end
    priority if (set_v) occ_nxt = occ_r + OCC_W'(1);
    else if (clr_v)     occ_nxt = occ_r - OCC_W'(1);
    else                occ_nxt = occ_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      occ_r     <= '0;
      next_id_r <= FIRST_ID;
      policy_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        policy_r <= cfg_data;
      end
      if (cmd.commit) begin
        occ_r <= occ_nxt;
        if (set_v) begin
          valid_r[best_idx_r] <= 1'b1;
          next_id_r <= (next_id_r == '1) ? FIRST_ID : next_id_r + ID_W'(1);
        end
        if (clr_v) begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_rem_r    <= res_rem;
      out_ret_r    <= res_ret;
      out_occ_r    <= occ_nxt;
    end
  end

  assign sts.out_busy  = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_result_id = out_id_r;
  assign out_remaining = out_rem_r;
  assign out_retired   = out_ret_r;
  assign out_occupancy = out_occ_r;

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == OCC_W'($countones(valid_r)))
    else $error("occupancy count out of step with valid bits");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != '0)
    else $error("id counter reached zero");

  a_commit_not_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

endmodule
`default_nettype wire
